// ===== design/pctd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared types, character codes and decode functions for the percent-escape
// decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } pctd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } pctd_out_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } pctd_phase_t;

  // Results written into the output queue by one accepted word.
  typedef struct packed {
    logic      push0;
    logic      push1;
    pctd_out_t res0;
    pctd_out_t res1;
  } pctd_push_t;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] TAB_CHAR   = 8'h09;
  localparam logic [7:0] CR_CHAR    = 8'h0D;

  localparam int unsigned QUEUE_DEPTH = 3;

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == SPACE_CHAR) || (c >= TAB_CHAR && c <= CR_CHAR);
  endfunction

  // Value of a two-character escape, as a base-16 parse truncated to 8 bits.
  function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] ha;
    logic [4:0] hb;
    logic [7:0] r;
    ha = hex_digit(a);
    hb = hex_digit(b);
    r  = 8'd0;
    if (ha[4]) begin
      r = hb[4] ? {ha[3:0], hb[3:0]} : {4'h0, ha[3:0]};
    end else if (hb[4]) begin
      if (is_space(a) || a == PLUS_CHAR) begin
        r = {4'h0, hb[3:0]};
      end else if (a == MINUS_CHAR) begin
        r = 8'd0 - {4'h0, hb[3:0]};
      end
    end
    return r;
  endfunction

endpackage

// ===== design/percent_escape_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_escape_decoder_unit
// Streaming URL percent-escape decoder, one character word in per cycle when not stalled.
// ----------------------------------------------------------------------------
// The block takes one URL character per cycle while in_stall is low and
// returns decoded bytes registered in a three-entry result queue. A '%' and the
// character after it produce no output; the third character completes the
// escape and yields one byte. An escape cut off by the end of the URL yields
// its characters literally, which for '%' plus one character means two
// output words; the input is stalled while the queue holds two or more
// words, so the sustained rate is one word per cycle when the output is not
// stalled, and the input stall is set only by queue occupancy.
module percent_escape_decoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pctd_pkg::pctd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pctd_pkg::pctd_out_t out_data
);

  pctd_pkg::pctd_push_t  push;
  pctd_pkg::pctd_phase_t phase;
  logic [1:0]            level;
  logic                  in_accept;

  assign in_stall  = (level > 2'd1);
  assign in_accept = in_valid && !in_stall;

  pctd_decoder u_decoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_data (in_data),
    .push    (push),
    .phase   (phase)
  );

  pctd_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .level     (level),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A second result word is only ever written together with a first one.
  a_push_pair: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0)
    else $error("second result written without a first");

  // Two words come only from an escape cut short after one character.
  a_two_words: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> (phase == pctd_pkg::PH_PCT && in_data.in_last && in_accept))
    else $error("two result words outside a truncated escape");

  // A '%' that opens an escape in idle produces no output.
  a_pct_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && phase == pctd_pkg::PH_IDLE && in_data.in_byte == pctd_pkg::PCT_CHAR
     && !in_data.in_last) |-> !push.push0)
    else $error("escape start produced an output word");

  // Reset leaves the output queue empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// ===== design/pctd_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_decoder
// Escape state machine: tracks the position inside a percent escape and
// forms zero, one or two result words for each accepted input word.
// ----------------------------------------------------------------------------
module pctd_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  pctd_pkg::pctd_in_t   in_data,
  output pctd_pkg::pctd_push_t push,
  output pctd_pkg::pctd_phase_t phase
);

  pctd_pkg::pctd_phase_t phase_r, phase_nxt;
  logic [7:0]            held_digit_r, held_digit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= pctd_pkg::PH_IDLE;
      held_digit_r <= 8'd0;
    end else begin
      phase_r      <= phase_nxt;
      held_digit_r <= held_digit_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    held_digit_nxt = held_digit_r;
    push           = '0;
    if (accept) begin
      case (phase_r)
        pctd_pkg::PH_PCT: begin
          held_digit_nxt = in_data.in_byte;
          if (in_data.in_last) begin
            // The escape is cut short: give back the '%' and the one character.
            phase_nxt          = pctd_pkg::PH_IDLE;
            push.push0         = 1'b1;
            push.res0.out_byte = pctd_pkg::PCT_CHAR;
            push.res0.out_last = 1'b0;
            push.push1         = 1'b1;
            push.res1.out_byte = in_data.in_byte;
            push.res1.out_last = 1'b1;
          end else begin
            phase_nxt = pctd_pkg::PH_DIGIT;
          end
        end
        pctd_pkg::PH_DIGIT: begin
          phase_nxt          = pctd_pkg::PH_IDLE;
          push.push0         = 1'b1;
          push.res0.out_byte = pctd_pkg::pair_value(held_digit_r, in_data.in_byte);
          push.res0.out_last = in_data.in_last;
        end
        default: begin
          if (in_data.in_byte == pctd_pkg::PCT_CHAR && !in_data.in_last) begin
            phase_nxt = pctd_pkg::PH_PCT;
          end else begin
            phase_nxt          = pctd_pkg::PH_IDLE;
            push.push0         = 1'b1;
            push.res0.out_byte = in_data.in_byte;
            push.res0.out_last = in_data.in_last;
          end
        end
      endcase
    end
  end

  assign phase = phase_r;

endmodule

// ===== design/pctd_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_out_queue
// Three-entry result queue that takes up to two words per cycle and hands
// one word per cycle to the output channel while out_stall is low.
// ----------------------------------------------------------------------------
module pctd_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pctd_pkg::pctd_push_t push,
  output logic [1:0]           level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pctd_pkg::pctd_out_t  out_data
);

  pctd_pkg::pctd_out_t mem_r [pctd_pkg::QUEUE_DEPTH];
  logic [1:0]          head_r, head_nxt;
  logic [1:0]          level_r, level_nxt;
  logic [1:0]          tail0;
  logic [1:0]          tail1;
  logic                pop;

  function automatic logic [1:0] wrap(input logic [2:0] x);
    logic [2:0] r;
    r = (x >= 3'(pctd_pkg::QUEUE_DEPTH)) ? x - 3'(pctd_pkg::QUEUE_DEPTH) : x;
    return r[1:0];
  endfunction

  assign tail0     = wrap({1'b0, head_r} + {1'b0, level_r});
  assign tail1     = wrap({1'b0, tail0} + 3'd1);
  assign out_valid = (level_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem_r[head_r];
  assign level     = level_r;

  always_comb begin
    head_nxt  = pop ? wrap({1'b0, head_r} + 3'd1) : head_r;
    level_nxt = level_r + {1'b0, push.push0} + {1'b0, push.push1} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 2'd0;
      level_r <= 2'd0;
    end else begin
      head_r  <= head_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < pctd_pkg::QUEUE_DEPTH; i++) begin
      if (push.push0 && tail0 == 2'(i)) begin
        mem_r[i] <= push.res0;
      end else if (push.push1 && tail1 == 2'(i)) begin
        mem_r[i] <= push.res1;
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for percent_escape_decoder_unit: directed escapes and random URL
// streams under varying idle and stall pressure, checked word by word
// against a behavioral decoder.
// ----------------------------------------------------------------------------
module tb;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  pctd_pkg::pctd_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  pctd_pkg::pctd_out_t out_data;

  // Idle and stall rates in percent, and a pending receiver hold-off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned n_errors = 0;

  // Decoder state as the testbench tracks it.
  pctd_pkg::pctd_phase_t esc_phase = pctd_pkg::PH_IDLE;
  logic [7:0]            esc_first = 8'd0;
  pctd_pkg::pctd_out_t   decoded_words[$];

  percent_escape_decoder_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Returns the digit value, or -1 for a character that is not hex.
  function automatic int hex_of(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30;
    if (c inside {[8'h41:8'h46]}) return int'(c) - 'h41 + 10;
    if (c inside {[8'h61:8'h66]}) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  // Base-16 parse of the two characters after '%', truncated to a byte.
  function automatic logic [7:0] escape_value(input logic [7:0] a, input logic [7:0] b);
    int va;
    int vb;
    va = hex_of(a);
    vb = hex_of(b);
    if (va >= 0) return (vb >= 0) ? 8'(va * 16 + vb) : 8'(va);
    if (vb < 0) return 8'd0;
    if (a == 8'h20 || (a >= 8'h09 && a <= 8'h0D) || a == pctd_pkg::PLUS_CHAR) return 8'(vb);
    if (a == pctd_pkg::MINUS_CHAR) return 8'(256 - vb);
    return 8'd0;
  endfunction

  task automatic decode_word(input pctd_pkg::pctd_in_t w);
    case (esc_phase)
      pctd_pkg::PH_PCT: begin
        esc_first = w.in_byte;
        if (w.in_last) begin
          // Escape cut off after one character: both go out literally.
          decoded_words.push_back('{out_byte: pctd_pkg::PCT_CHAR, out_last: 1'b0});
          decoded_words.push_back('{out_byte: w.in_byte, out_last: 1'b1});
          esc_phase = pctd_pkg::PH_IDLE;
        end else begin
          esc_phase = pctd_pkg::PH_DIGIT;
        end
      end
      pctd_pkg::PH_DIGIT: begin
        decoded_words.push_back('{out_byte: escape_value(esc_first, w.in_byte),
                                  out_last: w.in_last});
        esc_phase = pctd_pkg::PH_IDLE;
      end
      default: begin
        if (w.in_byte == pctd_pkg::PCT_CHAR && !w.in_last) begin
          esc_phase = pctd_pkg::PH_PCT;
        end else begin
          decoded_words.push_back('{out_byte: w.in_byte, out_last: w.in_last});
          esc_phase = pctd_pkg::PH_IDLE;
        end
      end
    endcase
  endtask

  task automatic check_word(input pctd_pkg::pctd_out_t got);
    pctd_pkg::pctd_out_t want;
    if (decoded_words.size() == 0) begin
      $error("unexpected output word: out_byte %02h out_last %0b", got.out_byte, got.out_last);
      n_errors++;
    end else begin
      want = decoded_words.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
        n_errors++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last: expected %0b, actual %0b", want.out_last, got.out_last);
        n_errors++;
      end
    end
  endtask

  // Both handshakes are judged on the values present just before the edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) decode_word(in_data);
    if (rst_n && out_valid && !out_stall) check_word(out_data);
  end

  always @(posedge clk) begin : receiver
    int unsigned hold_left;
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Valid stays high from one word to the next unless an idle cycle is drawn.
  task automatic send_word(input logic [7:0] b, input logic l);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, in_last: l};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_string(input string s, input logic ends_url);
    for (int k = 0; k < s.len(); k++) begin
      send_word(s[k], ends_url && (k == s.len() - 1));
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (decoded_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Characters that matter to the escape logic are drawn often.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: return 8'h30 + 8'($urandom_range(9, 0));
      4, 5:       return 8'h41 + 8'($urandom_range(5, 0));
      6:          return 8'h61 + 8'($urandom_range(5, 0));
      7: begin
        case ($urandom_range(3, 0))
          0:       return pctd_pkg::SPACE_CHAR;
          1:       return pctd_pkg::TAB_CHAR + 8'($urandom_range(4, 0));
          2:       return pctd_pkg::PLUS_CHAR;
          default: return pctd_pkg::MINUS_CHAR;
        endcase
      end
      default:    return 8'($urandom_range(255, 1));
    endcase
  endfunction

  task automatic send_random_urls(input int unsigned n_words);
    logic [7:0] url[$];
    int unsigned url_len;
    int unsigned sent;
    sent = 0;
    while (sent < n_words) begin
      url_len = $urandom_range(12, 1);
      url = {};
      while (url.size() < url_len) begin
        if ($urandom_range(9, 0) < 6) begin
          url.push_back(pctd_pkg::PCT_CHAR);
          url.push_back(pick_char());
          url.push_back(pick_char());
        end else begin
          url.push_back(8'($urandom_range(255, 1)));
        end
      end
      // Trimming to length can cut an escape short at the end of the URL.
      while (url.size() > url_len) void'(url.pop_back());
      for (int k = 0; k < url.size(); k++) begin
        send_word(url[k], k == url.size() - 1);
      end
      sent += url_len;
    end
  endtask

  task automatic test_passthrough();
    send_word(8'h01, 1'b0);
    send_word(8'hFF, 1'b1);
    wait_drain();
  endtask

  task automatic test_hex_escapes();
    send_string("%Ff", 1'b0);
    send_string("%00", 1'b1);
    wait_drain();
  endtask

  task automatic test_odd_pairs();
    send_string("%7z", 1'b0);
    send_string("%+c", 1'b0);
    send_string("%-1", 1'b0);
    send_word(pctd_pkg::PCT_CHAR, 1'b0);
    send_word(pctd_pkg::TAB_CHAR, 1'b0);
    send_word("5", 1'b0);
    send_string("%gZ", 1'b1);
    wait_drain();
  endtask

  task automatic test_cut_off();
    send_word(pctd_pkg::PCT_CHAR, 1'b1);
    send_string("%Z", 1'b1);
    wait_drain();
  endtask

  // A long receiver hold-off fills the result queue and backs up the input.
  task automatic test_queue_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 120;
    send_random_urls(30);
    wait_drain();
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 0;  recv_stall_pct = 0;
    send_random_urls(100);
    wait_drain();
    send_idle_pct = 71; recv_stall_pct = 0;
    send_random_urls(100);
    wait_drain();
    send_idle_pct = 0;  recv_stall_pct = 71;
    send_random_urls(100);
    wait_drain();
    send_idle_pct = 16; recv_stall_pct = 16;
    send_random_urls(100);
    wait_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_passthrough();
    test_hex_escapes();
    test_odd_pairs();
    test_cut_off();
    test_queue_fill();
    test_random_traffic();
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
